[hw/rtl/pmqd_pkg.sv]
// Shared types, constants and helpers of the priority multi-queue dispatcher.
package pmqd_pkg;

	localparam int NUM_QUEUES_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NUM_PRIO_DEF    = 3;

	localparam int MAP_W     = 16;
	localparam int QID_W     = 3;
	localparam int JOB_W     = 32;
	localparam int HANDLE_W  = 7;
	localparam int PENDING_W = 8;
	localparam int MAP_QUEUES = MAP_W / 2;

	localparam logic       CMD_ENQ   = 1'b0;
	localparam logic       CMD_DEQ   = 1'b1;
	localparam logic [1:0] PRIO_NONE = 2'd3;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_QUEUE = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EXEC,
		CS_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} dp_cmd_t;

	function automatic logic [1:0] level_of(input logic [MAP_W-1:0] map, input logic [4:0] idx);
		logic [MAP_W-1:0] sh;
		sh = map >> (5'd2 * idx);
		if (idx >= 5'(MAP_QUEUES)) begin
			level_of = PRIO_NONE;
		end else begin
			level_of = sh[1:0];
		end
	endfunction

endpackage

[hw/rtl/priority_multi_queue_dispatcher.sv]
// Top level of the strict-priority multi-queue job dispatcher.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | cmd, queue_id, job_code, job_arg
//  out     | output    | out_valid / out_stall| status, out_job_code, out_job_arg,
//          |           |                      | source_queue, item_handle, pending_total
//  cfg     | input     | cfg_we               | cfg_wdata (queue_priority_map)
//
// Each command passes through accept, execute and present-result steps.
// The next command is accepted the cycle after the result transfers; the job
// memory read is registered, which sets the execute-then-present sequence.
// Reset clears pointers, fill counts and the pending count; no memory clearing.
// A stalled result holds and the input stays stalled until it transfers.
module priority_multi_queue_dispatcher #(
	parameter int NUM_QUEUES  = pmqd_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = pmqd_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_PRIO    = pmqd_pkg::NUM_PRIO_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pmqd_pkg::MAP_W-1:0]       cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd,
	input  logic [pmqd_pkg::QID_W-1:0]       queue_id,
	input  logic [pmqd_pkg::JOB_W-1:0]       job_code,
	input  logic [pmqd_pkg::JOB_W-1:0]       job_arg,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic [pmqd_pkg::JOB_W-1:0]       out_job_code,
	output logic [pmqd_pkg::JOB_W-1:0]       out_job_arg,
	output logic [pmqd_pkg::QID_W-1:0]       source_queue,
	output logic [pmqd_pkg::HANDLE_W-1:0]    item_handle,
	output logic [pmqd_pkg::PENDING_W-1:0]   pending_total
);

	pmqd_pkg::dp_cmd_t dp_cmd;

	pmqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd)
	);

	pmqd_dp #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_PRIO    (NUM_PRIO)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.dp_cmd        (dp_cmd),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.queue_id      (queue_id),
		.job_code      (job_code),
		.job_arg       (job_arg),
		.status        (status),
		.out_job_code  (out_job_code),
		.out_job_arg   (out_job_arg),
		.source_queue  (source_queue),
		.item_handle   (item_handle),
		.pending_total (pending_total)
	);

endmodule

[hw/rtl/pmqd_ctrl.sv]
// Command sequencer of the dispatcher: accept, execute, hold result until transfer.
module pmqd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output pmqd_pkg::dp_cmd_t  dp_cmd
);

	pmqd_pkg::ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmqd_pkg::CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pmqd_pkg::CS_IDLE: begin
				if (in_valid) state_nxt = pmqd_pkg::CS_EXEC;
			end
			pmqd_pkg::CS_EXEC: begin
				state_nxt = pmqd_pkg::CS_DONE;
			end
			pmqd_pkg::CS_DONE: begin
				if (!out_stall) state_nxt = pmqd_pkg::CS_IDLE;
			end
			default: begin
				state_nxt = pmqd_pkg::CS_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall       = 1'b1;
		out_valid      = 1'b0;
		dp_cmd.capture = 1'b0;
		dp_cmd.execute = 1'b0;
		unique case (state_q)
			pmqd_pkg::CS_IDLE: begin
				in_stall       = 1'b0;
				dp_cmd.capture = in_valid;
			end
			pmqd_pkg::CS_EXEC: begin
				dp_cmd.execute = 1'b1;
			end
			pmqd_pkg::CS_DONE: begin
				out_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

[hw/rtl/pmqd_dp.sv]
// Datapath of the dispatcher: queue pointers, fill counts, priority pick and job memory.
module pmqd_dp #(
	parameter int NUM_QUEUES  = pmqd_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = pmqd_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_PRIO    = pmqd_pkg::NUM_PRIO_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pmqd_pkg::dp_cmd_t                dp_cmd,
	input  logic                             cfg_we,
	input  logic [pmqd_pkg::MAP_W-1:0]       cfg_wdata,
	input  logic                             cmd,
	input  logic [pmqd_pkg::QID_W-1:0]       queue_id,
	input  logic [pmqd_pkg::JOB_W-1:0]       job_code,
	input  logic [pmqd_pkg::JOB_W-1:0]       job_arg,
	output logic [1:0]                       status,
	output logic [pmqd_pkg::JOB_W-1:0]       out_job_code,
	output logic [pmqd_pkg::JOB_W-1:0]       out_job_arg,
	output logic [pmqd_pkg::QID_W-1:0]       source_queue,
	output logic [pmqd_pkg::HANDLE_W-1:0]    item_handle,
	output logic [pmqd_pkg::PENDING_W-1:0]   pending_total
);

	localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW    = $clog2(QUEUE_DEPTH);
	localparam int FW    = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLW   = (AW > pmqd_pkg::HANDLE_W) ? AW : pmqd_pkg::HANDLE_W;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int PTW   = (CW > pmqd_pkg::PENDING_W) ? CW : pmqd_pkg::PENDING_W;
	localparam int DW    = 2 * pmqd_pkg::JOB_W;

	logic [pmqd_pkg::MAP_W-1:0] map_q;
	logic                       cmd_q;
	logic [pmqd_pkg::QID_W-1:0] qid_q;
	logic [pmqd_pkg::JOB_W-1:0] code_q;
	logic [pmqd_pkg::JOB_W-1:0] arg_q;

	logic [PW-1:0] head_q [NUM_QUEUES];
	logic [PW-1:0] tail_q [NUM_QUEUES];
	logic [FW-1:0] fill_q [NUM_QUEUES];
	logic [CW-1:0] pend_q;

	logic [DW-1:0] mem [SLOTS];
	logic [DW-1:0] rd_q;

	logic [1:0]                    res_status_q;
	logic                          res_deq_q;
	logic [pmqd_pkg::QID_W-1:0]    res_src_q;
	logic [pmqd_pkg::HANDLE_W-1:0] res_handle_q;

	logic [1:0]       lvl [NUM_QUEUES];
	logic             elig [NUM_QUEUES];
	logic             pick_found;
	logic [QW-1:0]    pick_q;
	logic             enq_in_range;
	logic             enq_created;
	logic [QW-1:0]    qsel;
	logic             enq_full;
	logic             is_enq;
	logic             enq_ok;
	logic             deq_ok;
	logic [QW-1:0]    acc_q;
	logic [PW-1:0]    acc_ptr;
	logic [SLW-1:0]   slot_w;
	logic [AW-1:0]    addr;
	pmqd_pkg::status_t exec_status;
	logic [PTW-1:0]   pend_w;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '1;
		end else if (cfg_we) begin
			map_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q  <= cmd;
			qid_q  <= queue_id;
			code_q <= job_code;
			arg_q  <= job_arg;
		end
	end

	always_comb begin
		for (int q = 0; q < NUM_QUEUES; q++) begin
			lvl[q]  = pmqd_pkg::level_of(map_q, 5'(q));
			elig[q] = (lvl[q] < 2'(NUM_PRIO)) && (fill_q[q] != '0);
		end
	end

	always_comb begin
		logic          lv_found;
		logic [QW-1:0] lv_q;
		pick_found = 1'b0;
		pick_q     = '0;
		for (int lv = NUM_PRIO - 1; lv >= 0; lv--) begin
			lv_found = 1'b0;
			lv_q     = '0;
			for (int q = 0; q < NUM_QUEUES; q++) begin
				if (elig[q] && (lvl[q] == 2'(lv))) begin
					lv_found = 1'b1;
					lv_q     = QW'(q);
				end
			end
			if (lv_found) begin
				pick_found = 1'b1;
				pick_q     = lv_q;
			end
		end
	end

	always_comb begin
		is_enq       = (cmd_q == pmqd_pkg::CMD_ENQ);
		enq_in_range = (int'(qid_q) < NUM_QUEUES);
		qsel         = enq_in_range ? QW'(qid_q) : '0;
		enq_created  = enq_in_range &&
			(pmqd_pkg::level_of(map_q, 5'(qid_q)) < 2'(NUM_PRIO));
		enq_full     = (fill_q[qsel] == FW'(QUEUE_DEPTH));
		enq_ok       = is_enq && enq_created && !enq_full;
		deq_ok       = !is_enq && pick_found;
		if (is_enq) begin
			if (!enq_created) begin
				exec_status = pmqd_pkg::ST_NO_QUEUE;
			end else if (enq_full) begin
				exec_status = pmqd_pkg::ST_FULL;
			end else begin
				exec_status = pmqd_pkg::ST_OK;
			end
		end else begin
			exec_status = pick_found ? pmqd_pkg::ST_OK : pmqd_pkg::ST_EMPTY;
		end
		acc_q   = is_enq ? qsel : pick_q;
		acc_ptr = is_enq ? tail_q[qsel] : head_q[pick_q];
		slot_w  = SLW'(acc_q) * SLW'(QUEUE_DEPTH) + SLW'(acc_ptr);
		addr    = AW'(slot_w);
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.execute && enq_ok) begin
			mem[addr] <= {code_q, arg_q};
		end
		if (dp_cmd.execute && deq_ok) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				head_q[q] <= '0;
				tail_q[q] <= '0;
				fill_q[q] <= '0;
			end
			pend_q <= '0;
		end else if (dp_cmd.execute) begin
			if (enq_ok) begin
				tail_q[qsel] <= ptr_inc(tail_q[qsel]);
				fill_q[qsel] <= fill_q[qsel] + FW'(1);
				pend_q       <= pend_q + CW'(1);
			end else if (deq_ok) begin
				head_q[pick_q] <= ptr_inc(head_q[pick_q]);
				fill_q[pick_q] <= fill_q[pick_q] - FW'(1);
				pend_q         <= pend_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.execute) begin
			res_status_q <= exec_status;
			res_deq_q    <= deq_ok;
			res_src_q    <= deq_ok ? pmqd_pkg::QID_W'(pick_q) : '0;
			res_handle_q <= enq_ok ? slot_w[pmqd_pkg::HANDLE_W-1:0] : '0;
		end
	end

	assign pend_w        = PTW'(pend_q);
	assign status        = res_status_q;
	assign out_job_code  = res_deq_q ? rd_q[DW-1:pmqd_pkg::JOB_W] : '0;
	assign out_job_arg   = res_deq_q ? rd_q[pmqd_pkg::JOB_W-1:0] : '0;
	assign source_queue  = res_src_q;
	assign item_handle   = res_handle_q;
	assign pending_total = pend_w[pmqd_pkg::PENDING_W-1:0];

	a_enq_counts: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.execute && enq_ok |=> pend_q == $past(pend_q) + CW'(1))
		else $error("pending count did not rise on enqueue");

	a_deq_counts: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.execute && deq_ok |=> pend_q == $past(pend_q) - CW'(1))
		else $error("pending count did not fall on dequeue");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!dp_cmd.execute |=> pend_q == $past(pend_q))
		else $error("pending count moved without a command");

	a_full_real: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.execute && exec_status == pmqd_pkg::ST_FULL |->
		is_enq && fill_q[qsel] == FW'(QUEUE_DEPTH))
		else $error("full status on a queue with room");

endmodule
